// ===== sv/fdr_pkg.sv =====
// Shared types, constants and reset values for the feedback delay reverb.
package fdr_pkg;

	// Default geometry of the history ring.
	localparam int CHUNK_LEN_DEF = 256;
	localparam int NCHUNKS_DEF   = 64;

	// Saturation bound of every sum, fixed by the 16-bit sample width.
	localparam int PEAK_LEVEL = 32767;

	// Widths of the sample and of the configuration registers.
	localparam int SAMPLE_W = 16;
	localparam int GAIN_W   = 9;
	localparam int DELAY_W  = 6;
	localparam int CFG_W    = 9;

	// Reset values of the configuration registers.
	localparam logic [GAIN_W-1:0]  DRY_RST   = 9'd254;
	localparam logic [GAIN_W-1:0]  WET_RST   = 9'd80;
	localparam logic [GAIN_W-1:0]  REGEN_RST = 9'd100;
	localparam logic [DELAY_W-1:0] DELAY_RST = 6'd19;

	// Register indexes on the configuration port.
	typedef enum logic [1:0] {
		REG_DRY   = 2'd0,
		REG_WET   = 2'd1,
		REG_REGEN = 2'd2,
		REG_DELAY = 2'd3
	} reg_idx_t;

endpackage

// ===== sv/feedback_delay_reverb_unit.sv =====
// Feedback comb filter with a delay of whole chunks, five-stage pipeline.
// One beat per cycle sustained while the output side is ready and no hazard holds the input.
// Throughput is set by the single read and single write port of the history RAM; when the
// delay spans 4 samples or fewer, an input waits until its read-back result is written.
// Reset (arst_n low) empties the pipeline, zeroes the pointers and restores the gains;
// the history reads as zero until written through a fill flag, so there is no clearing pass.
module feedback_delay_reverb_unit #(
	parameter int CHUNK_LEN = fdr_pkg::CHUNK_LEN_DEF,
	parameter int NCHUNKS   = fdr_pkg::NCHUNKS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// Input stream; tdata: sample_in [15:0].
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [fdr_pkg::SAMPLE_W-1:0] s_tdata,
	// Output stream; tdata: sample_out [15:0].
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [fdr_pkg::SAMPLE_W-1:0] m_tdata,
	// Configuration write port.
	input  logic                         cfg_we,
	input  logic [1:0]                   cfg_addr,
	input  logic [fdr_pkg::CFG_W-1:0]    cfg_data
);

	import fdr_pkg::*;

	localparam int RING_LEN = NCHUNKS * CHUNK_LEN;
	localparam int AW       = $clog2(RING_LEN);
	localparam logic [AW-1:0] LAST_ADDR = AW'(RING_LEN - 1);

	// Truncating division by 256 of a 26-bit signed product.
	function automatic logic signed [17:0] div256(input logic signed [25:0] p);
		logic signed [25:0] t;
		t = p + (p[25] ? 26'sd255 : 26'sd0);
		return t[25:8];
	endfunction

	// Saturation of a 19-bit signed sum to the sample range.
	function automatic logic signed [15:0] sat(input logic signed [18:0] v);
		logic signed [15:0] r;
		if (v > 19'(PEAK_LEVEL)) begin
			r = 16'(PEAK_LEVEL);
		end else if (v < -19'(PEAK_LEVEL)) begin
			r = -16'(PEAK_LEVEL);
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

	// Configuration registers.
	logic [GAIN_W-1:0]  dry_q, wet_q, regen_q;
	logic [DELAY_W-1:0] delay_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dry_q   <= DRY_RST;
			wet_q   <= WET_RST;
			regen_q <= REGEN_RST;
			delay_q <= DELAY_RST;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_addr))
				REG_DRY:   dry_q   <= cfg_data[GAIN_W-1:0];
				REG_WET:   wet_q   <= cfg_data[GAIN_W-1:0];
				REG_REGEN: regen_q <= cfg_data[GAIN_W-1:0];
				REG_DELAY: delay_q <= cfg_data[DELAY_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Pipeline control.
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic en1, en2, en3, en4, en5;
	logic hazard, accept;

	assign en5 = !valid_s5 || m_tready;
	assign en4 = !valid_s4 || en5;
	assign en3 = !valid_s3 || en4;
	assign en2 = !valid_s2 || en3;
	assign en1 = !valid_s1 || en2;

	// Delay clamp and read address.
	logic [DELAY_W-1:0] dd;
	logic [AW-1:0]      back;
	logic [AW-1:0]      wp_q, wr_q;
	logic               wrapped_q;
	logic [AW-1:0]      rd_addr;
	logic               old_valid;
	logic [2:0]         inflight;

	always_comb begin
		if (delay_q == '0) begin
			dd = DELAY_W'(1);
		end else if (32'(delay_q) >= 32'(NCHUNKS)) begin
			dd = DELAY_W'(NCHUNKS - 1);
		end else begin
			dd = delay_q;
		end
		back = AW'(32'(dd) * 32'(CHUNK_LEN));
		if (wp_q >= back) begin
			rd_addr = wp_q - back;
		end else begin
			rd_addr = AW'({1'b0, wp_q} + (AW+1)'(RING_LEN) - {1'b0, back});
		end
		// Before the first wrap only slots below the write pointer hold results.
		old_valid = wrapped_q || (wp_q >= back);
	end

	// Items accepted whose result is not yet in the RAM.
	assign inflight = 3'(valid_s1) + 3'(valid_s2) + 3'(valid_s3) + 3'(valid_s4);
	assign hazard   = (32'(back) <= 32'(inflight));
	assign s_tready = en1 && !hazard;
	assign accept   = s_tvalid && s_tready;

	// Read pointer side: advances on each accepted beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q      <= '0;
			wrapped_q <= 1'b0;
		end else if (accept) begin
			if (wp_q == LAST_ADDR) begin
				wp_q      <= '0;
				wrapped_q <= 1'b1;
			end else begin
				wp_q <= wp_q + AW'(1);
			end
		end
	end

	// History RAM.
	logic               ram_we;
	logic [SAMPLE_W-1:0] ram_rdata;
	logic signed [15:0] res;

	assign ram_we = en5 && valid_s4;

	fdr_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (RING_LEN)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wr_q),
		.wdata (res),
		.re    (en1),
		.raddr (rd_addr),
		.rdata (ram_rdata)
	);

	// Write pointer side: advances on each result written.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
		end else if (ram_we) begin
			wr_q <= (wr_q == LAST_ADDR) ? '0 : wr_q + AW'(1);
		end
	end

	// Valid bits of the stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (en1) valid_s1 <= accept;
			if (en2) valid_s2 <= valid_s1;
			if (en3) valid_s3 <= valid_s2;
			if (en4) valid_s4 <= valid_s3;
			if (en5) valid_s5 <= valid_s4;
		end
	end

	// Stage 1: input sample and fill flag, RAM read in flight.
	logic signed [15:0] x_s1;
	logic               vold_s1;

	always_ff @(posedge clk) begin
		if (en1) begin
			x_s1    <= s_tdata;
			vold_s1 <= old_valid;
		end
	end

	// Stage 2: dry and wet products.
	logic signed [15:0] old_eff;
	logic signed [25:0] pdry_s2, pwet_s2;
	logic signed [15:0] x_s2;

	assign old_eff = vold_s1 ? ram_rdata : '0;

	always_ff @(posedge clk) begin
		if (en2) begin
			pdry_s2 <= x_s1 * $signed({1'b0, dry_q});
			pwet_s2 <= old_eff * $signed({1'b0, wet_q});
			x_s2    <= x_s1;
		end
	end

	// Stage 3: scaled mix, saturated.
	logic signed [18:0] mix_sum;
	logic signed [15:0] mix_s3, x_s3;

	assign mix_sum = 19'(div256(pdry_s2)) + 19'(div256(pwet_s2));

	always_ff @(posedge clk) begin
		if (en3) begin
			mix_s3 <= sat(mix_sum);
			x_s3   <= x_s2;
		end
	end

	// Stage 4: feedback product.
	logic signed [25:0] preg_s4;
	logic signed [15:0] x_s4;

	always_ff @(posedge clk) begin
		if (en4) begin
			preg_s4 <= mix_s3 * $signed({1'b0, regen_q});
			x_s4    <= x_s3;
		end
	end

	// Stage 5: result, saturated; also written to the history.
	logic signed [15:0] sample_out_s5;

	assign res = sat(19'(div256(preg_s4)) + 19'(x_s4));

	always_ff @(posedge clk) begin
		if (en5) begin
			sample_out_s5 <= res;
		end
	end

	assign m_tvalid = valid_s5;
	assign m_tdata  = sample_out_s5;

endmodule

// ===== sv/fdr_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module fdr_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port; the data holds while re is low.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== sv/fdr_checker.sv =====
// Port-level checker for the feedback delay reverb, bound to the top level.
module fdr_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         s_tvalid,
	input logic                         s_tready,
	input logic                         m_tvalid,
	input logic                         m_tready,
	input logic [fdr_pkg::SAMPLE_W-1:0] m_tdata
);

	import fdr_pkg::*;

	// Beats inside the block: accepted but not yet delivered.
	logic [3:0] outstanding_q;
	logic       in_beat, out_beat;

	assign in_beat  = s_tvalid && s_tready;
	assign out_beat = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outstanding_q <= '0;
		end else begin
			outstanding_q <= outstanding_q + 4'(in_beat) - 4'(out_beat);
		end
	end

	// A held output beat stays valid.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("output beat dropped while stalled");

	// Every output beat stems from an earlier input beat.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> outstanding_q != 4'd0)
		else $error("output beat without a matching input beat");

	// The five pipeline stages bound the beats in flight.
	assert property (@(posedge clk) disable iff (!arst_n)
		outstanding_q <= 4'd5)
		else $error("more beats in flight than pipeline stages");

	// Results are saturated symmetrically, so the most negative code never shows.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> $signed(m_tdata) >= -16'(PEAK_LEVEL))
		else $error("result below the negative saturation bound");

endmodule

bind feedback_delay_reverb_unit fdr_checker u_fdr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// ===== verif/reverb_checker.sv =====
`timescale 1ns / 1ps
// Stream watcher for the feedback delay reverb: predicts every output sample and compares it.
module reverb_checker #(
	parameter int CHUNK_LEN = fdr_pkg::CHUNK_LEN_DEF,
	parameter int NCHUNKS   = fdr_pkg::NCHUNKS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	input  logic                         s_tready,
	input  logic [fdr_pkg::SAMPLE_W-1:0] s_tdata,
	input  logic                         m_tvalid,
	input  logic                         m_tready,
	input  logic [fdr_pkg::SAMPLE_W-1:0] m_tdata,
	input  logic                         cfg_we,
	input  logic [1:0]                   cfg_addr,
	input  logic [fdr_pkg::CFG_W-1:0]    cfg_data,
	output int                           mismatch_count,
	output int                           due_count
);
	import fdr_pkg::*;

	localparam int RING_LEN   = CHUNK_LEN * NCHUNKS;

	// Private copy of the history ring and of the settings.
	logic signed [SAMPLE_W-1:0] history [RING_LEN];
	int unsigned                wr_ptr;
	logic [GAIN_W-1:0]          dry;
	logic [GAIN_W-1:0]          wet;
	logic [GAIN_W-1:0]          regen;
	logic [DELAY_W-1:0]         delay;

	// Output samples owed by the block, oldest first.
	logic signed [SAMPLE_W-1:0] due_samples [$];
	int                         errs = 0;

	function automatic longint clip(input longint v);
		if (v > PEAK_LEVEL)
			return PEAK_LEVEL;
		if (v < -PEAK_LEVEL)
			return -PEAK_LEVEL;
		return v;
	endfunction

	// Computes the comb filter output for one input and stores it in the history.
	function automatic logic signed [SAMPLE_W-1:0] comb_step(
		input logic signed [SAMPLE_W-1:0] x
	);
		int unsigned d;
		int unsigned rd;
		longint      old;
		longint      mix;
		longint      res;
		d = delay;
		if (d < 1)
			d = 1;
		if (d > NCHUNKS - 1)
			d = NCHUNKS - 1;
		rd  = (wr_ptr + RING_LEN - d * CHUNK_LEN) % RING_LEN;
		old = history[rd];
		// Signed division truncates toward zero, as the block does.
		mix = clip(longint'(x) * longint'(dry) / 256 + old * longint'(wet) / 256);
		res = clip(mix * longint'(regen) / 256 + longint'(x));
		history[wr_ptr] = res[SAMPLE_W-1:0];
		wr_ptr = (wr_ptr + 1) % RING_LEN;
		return res[SAMPLE_W-1:0];
	endfunction

	// Track settings, predict on input beats and compare on output beats.
	always @(posedge clk or negedge arst_n) begin : watch
		logic signed [SAMPLE_W-1:0] want;
		if (!arst_n) begin
			foreach (history[i])
				history[i] = '0;
			wr_ptr = 0;
			dry    = DRY_RST;
			wet    = WET_RST;
			regen  = REGEN_RST;
			delay  = DELAY_RST;
			due_samples.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					REG_DRY:   dry   = cfg_data[GAIN_W-1:0];
					REG_WET:   wet   = cfg_data[GAIN_W-1:0];
					REG_REGEN: regen = cfg_data[GAIN_W-1:0];
					REG_DELAY: delay = cfg_data[DELAY_W-1:0];
					default: ;
				endcase
			end
			// The output beat always belongs to an earlier input, so pop before push.
			if (m_tvalid && m_tready) begin
				if (due_samples.size() == 0) begin
					errs++;
					$error("sample_out: beat with nothing expected, expected none, actual %0d",
						$signed(m_tdata));
				end else begin
					want = due_samples.pop_front();
					if (m_tdata !== want) begin
						errs++;
						$error("sample_out: expected %0d, actual %0d", want,
							$signed(m_tdata));
					end
				end
			end
			if (s_tvalid && s_tready)
				due_samples.push_back(comb_step(s_tdata));
		end
		due_count      <= due_samples.size();
		mismatch_count <= errs;
	end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench top for the feedback delay reverb: clock, reset, stimulus and verdict.
module tb_top;
	import fdr_pkg::*;

	// Several times the slowest correct run of all phases together.
	localparam int LIMIT      = 250000;
	// Closing stretch without idling; the one-chunk delay reads results of earlier phases.
	localparam int TAIL_ITEMS = 96;

	logic                clk      = 1'b0;
	logic                arst_n   = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [SAMPLE_W-1:0] s_tdata  = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [SAMPLE_W-1:0] m_tdata;
	logic                cfg_we   = 1'b0;
	logic [1:0]          cfg_addr = '0;
	logic [CFG_W-1:0]    cfg_data = '0;

	int mismatch_count;
	int due_count;
	int cycles     = 0;
	bit idle_on    = 1'b0;
	bit hold_start = 1'b0;

	feedback_delay_reverb_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data)
	);

	reverb_checker reverb_chk (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.cfg_we         (cfg_we),
		.cfg_addr       (cfg_addr),
		.cfg_data       (cfg_data),
		.mismatch_count (mismatch_count),
		.due_count      (due_count)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// Watchdog.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Output side: random stall bursts, plus one long hold-off on request.
	initial begin : sink
		int gap;
		int hold;
		gap  = 0;
		hold = 0;
		forever begin
			@(posedge clk);
			if (hold > 0) begin
				hold--;
				m_tready <= 1'b0;
			end else if (hold_start) begin
				hold_start = 1'b0;
				hold       = 299;
				m_tready   <= 1'b0;
			end else if (gap > 0) begin
				gap--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if (idle_on && $urandom_range(0, 7) == 0)
					gap = $urandom_range(1, 18);
			end
		end
	end

	// Offers one sample and waits for its beat; may then leave a gap.
	task automatic send_sample(input logic [SAMPLE_W-1:0] v);
		int gap;
		s_tvalid <= 1'b1;
		s_tdata  <= v;
		do @(posedge clk); while (!s_tready);
		if (idle_on && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 18);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Stops offering and waits until every owed sample has come out.
	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (due_count != 0);
	endtask

	// Writes all four registers back to back while the block is idle.
	task automatic load_settings(input logic [CFG_W-1:0] dry_v, wet_v, regen_v, dly_v);
		logic [CFG_W-1:0] vals [4];
		vals = '{dry_v, wet_v, regen_v, dly_v};
		cfg_we <= 1'b1;
		for (int i = 0; i < 4; i++) begin
			cfg_addr <= reg_idx_t'(i);
			cfg_data <= vals[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	// Full-scale values, the rails, and small values that exercise truncation.
	function automatic logic [SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(0, 9))
			0:       return 16'h7FFF;
			1:       return 16'h8000;
			2:       return 16'h8001;
			3, 4:    return SAMPLE_W'(int'($urandom_range(0, 1023)) - 512);
			default: return SAMPLE_W'($urandom());
		endcase
	endfunction

	// Gains cover zero, the nominal top, and values up to the full register.
	function automatic logic [CFG_W-1:0] pick_gain();
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return 9'd258;
			2:       return 9'd511;
			3:       return CFG_W'($urandom_range(259, 511));
			default: return CFG_W'($urandom_range(0, 258));
		endcase
	endfunction

	// Short delays let the feedback show within the run; upper data bits are junk.
	function automatic logic [CFG_W-1:0] pick_delay();
		logic [CFG_W-1:0] v;
		v = CFG_W'($urandom());
		case ($urandom_range(0, 7))
			0, 1:    v[DELAY_W-1:0] = '0;
			2, 3, 4: v[DELAY_W-1:0] = 6'd1;
			5:       v[DELAY_W-1:0] = 6'd2;
			6:       v[DELAY_W-1:0] = 6'd63;
			default: v[DELAY_W-1:0] = DELAY_W'($urandom_range(3, 62));
		endcase
		return v;
	endfunction

	initial begin : stim
		logic [SAMPLE_W-1:0] corner_vals [12];
		int n;
		corner_vals = '{16'h0000, 16'h7FFF, 16'h8000, 16'h8001, 16'h0001, 16'hFFFF,
			16'h5555, 16'hAAAA, 16'h00FF, 16'hFF01, 16'h7FFE, 16'hFF80};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Corner samples under the reset settings.
		foreach (corner_vals[i])
			send_sample(corner_vals[i]);
		drain();

		// Largest gains; a delay of zero with stray upper bits is used as one chunk.
		load_settings(9'd511, 9'd511, 9'd511, 9'h1C0);
		foreach (corner_vals[i])
			send_sample(corner_vals[i]);
		drain();

		// Random settings and samples; one phase holds the output off for a long stretch.
		for (int p = 0; p < 8; p++) begin
			idle_on = ($urandom_range(0, 3) != 0);
			load_settings(pick_gain(), pick_gain(), pick_gain(), pick_delay());
			if (p == 2)
				hold_start = 1'b1;
			n = $urandom_range(25, 45);
			repeat (n)
				send_sample(pick_sample());
			drain();
		end

		// One chunk of delay and no idling, so the feedback of earlier phases comes back.
		idle_on = 1'b0;
		load_settings(CFG_W'($urandom_range(128, 258)), CFG_W'($urandom_range(100, 258)),
			CFG_W'($urandom_range(64, 200)), 9'h001);
		repeat (TAIL_ITEMS)
			send_sample(pick_sample());
		drain();
		repeat (8) @(posedge clk);

		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/fdr_pkg.sv
sv/fdr_ram.sv
sv/feedback_delay_reverb_unit.sv
sv/fdr_checker.sv
verif/reverb_checker.sv
verif/tb_top.sv
